>>> hw/rtl/qreq_pkg.sv
// Shared types, register map and range constants for the quantized requantizer.
package qreq_pkg;

   // Field widths.
   localparam int SAMPLE_W = 32;
   localparam int MULT_W   = 31;
   localparam int SHIFT_W  = 6;
   localparam int ZP_W     = 8;
   localparam int FMT_W    = 2;
   localparam int MAG_W    = 32;
   localparam int PROD_W   = MAG_W + MULT_W;
   localparam int WIDE_W   = 64;

   // Configuration port geometry: six 32-bit registers at byte addresses 4*i.
   localparam int ADDR_W   = 5;
   localparam int REGIDX_W = 3;
   localparam int DATA_W   = 32;

   // Register indexes.
   localparam logic [REGIDX_W-1:0] REG_SOURCE_FORMAT     = 3'd0;
   localparam logic [REGIDX_W-1:0] REG_DEST_FORMAT       = 3'd1;
   localparam logic [REGIDX_W-1:0] REG_SCALE_MULTIPLIER  = 3'd2;
   localparam logic [REGIDX_W-1:0] REG_SCALE_SHIFT       = 3'd3;
   localparam logic [REGIDX_W-1:0] REG_SOURCE_ZERO_POINT = 3'd4;
   localparam logic [REGIDX_W-1:0] REG_DEST_ZERO_POINT   = 3'd5;

   // Source format codes; the reserved code is handled as signed 32-bit.
   localparam logic [FMT_W-1:0] SRC_S32 = 2'd0;
   localparam logic [FMT_W-1:0] SRC_S8  = 2'd1;
   localparam logic [FMT_W-1:0] SRC_U8  = 2'd2;

   // Destination format codes; the reserved code is handled as signed 32-bit.
   localparam logic [FMT_W-1:0] DST_S8  = 2'd0;
   localparam logic [FMT_W-1:0] DST_S32 = 2'd1;
   localparam logic [FMT_W-1:0] DST_U8  = 2'd2;

   // Reset values of the registers.
   localparam logic [FMT_W-1:0]   RST_SOURCE_FORMAT    = SRC_S32;
   localparam logic [FMT_W-1:0]   RST_DEST_FORMAT      = DST_S8;
   localparam logic [MULT_W-1:0]  RST_SCALE_MULTIPLIER = 31'd1073741824;
   localparam logic [SHIFT_W-1:0] RST_SCALE_SHIFT      = 6'd30;
   localparam logic [ZP_W-1:0]    RST_ZERO_POINT       = 8'd0;

   // Saturation bounds of the destination ranges.
   localparam logic signed [WIDE_W-1:0] S8_MIN  = -64'sd128;
   localparam logic signed [WIDE_W-1:0] S8_MAX  = 64'sd127;
   localparam logic signed [WIDE_W-1:0] U8_MIN  = 64'sd0;
   localparam logic signed [WIDE_W-1:0] U8_MAX  = 64'sd255;
   localparam logic signed [WIDE_W-1:0] S32_MIN = -64'sd2147483648;
   localparam logic signed [WIDE_W-1:0] S32_MAX = 64'sd2147483647;

   // Configuration as seen by the datapath.
   typedef struct packed {
      logic [FMT_W-1:0]   source_format;
      logic [FMT_W-1:0]   dest_format;
      logic [MULT_W-1:0]  scale_multiplier;
      logic [SHIFT_W-1:0] scale_shift;
      logic [ZP_W-1:0]    source_zero_point;
      logic [ZP_W-1:0]    dest_zero_point;
   } cfg_type;

endpackage

>>> hw/rtl/quantized_requantizer.sv
// Requantizer top level: one sample in, one converted value out, every cycle while no stall holds the flow.
// The block converts one quantized sample per item from signed 32-bit, signed
// 8-bit or unsigned 8-bit asymmetric form into signed 8-bit, signed 32-bit or
// unsigned 8-bit asymmetric form, scaling by scale_multiplier times two to the
// minus scale_shift with rounding half away from zero and saturating to the
// destination range; rsp_clipped marks a saturated item. A new item is taken
// every clock cycle while req_stall is low; each item passes decode, a
// 32 by 31 bit multiply, the rounding shift, and the saturating output
// register. Empty stages keep closing up while rsp_stall is high, so req_stall
// rises only when all four stages hold an item and the output is stalled.
// Registers sit at byte addresses 4*i and should be written only while no
// item is in flight.
module quantized_requantizer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [qreq_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [qreq_pkg::SAMPLE_W-1:0] rsp_converted,
   output logic                                 rsp_clipped,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [qreq_pkg::ADDR_W-1:0]          csr_paddr,
   input  logic [qreq_pkg::DATA_W-1:0]          csr_pwdata,
   output logic [qreq_pkg::DATA_W-1:0]          csr_prdata,
   output logic                                 csr_pready
);

   qreq_pkg::cfg_type cfg;

   // Configuration registers.
   qreq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Conversion pipeline.
   qreq_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_sample    (req_sample),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_converted (rsp_converted),
      .rsp_clipped   (rsp_clipped)
   );

endmodule

>>> hw/rtl/qreq_csr.sv
// Configuration register file with an APB-style access port.
module qreq_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [qreq_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [qreq_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [qreq_pkg::DATA_W-1:0]   csr_prdata,
   output logic                          csr_pready,
   output qreq_pkg::cfg_type             cfg
);

   qreq_pkg::cfg_type                  cfg_ff;
   qreq_pkg::cfg_type                  cfg_in;
   logic                               wr_en;
   logic [qreq_pkg::REGIDX_W-1:0]      reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[qreq_pkg::ADDR_W-1:2];

   // Next register values: only the addressed register takes the write data.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            qreq_pkg::REG_SOURCE_FORMAT:
               cfg_in.source_format = csr_pwdata[qreq_pkg::FMT_W-1:0];
            qreq_pkg::REG_DEST_FORMAT:
               cfg_in.dest_format = csr_pwdata[qreq_pkg::FMT_W-1:0];
            qreq_pkg::REG_SCALE_MULTIPLIER:
               cfg_in.scale_multiplier = csr_pwdata[qreq_pkg::MULT_W-1:0];
            qreq_pkg::REG_SCALE_SHIFT:
               cfg_in.scale_shift = csr_pwdata[qreq_pkg::SHIFT_W-1:0];
            qreq_pkg::REG_SOURCE_ZERO_POINT:
               cfg_in.source_zero_point = csr_pwdata[qreq_pkg::ZP_W-1:0];
            qreq_pkg::REG_DEST_ZERO_POINT:
               cfg_in.dest_zero_point = csr_pwdata[qreq_pkg::ZP_W-1:0];
            default: ;
         endcase
      end
   end

   // Register storage with reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_format     <= qreq_pkg::RST_SOURCE_FORMAT;
         cfg_ff.dest_format       <= qreq_pkg::RST_DEST_FORMAT;
         cfg_ff.scale_multiplier  <= qreq_pkg::RST_SCALE_MULTIPLIER;
         cfg_ff.scale_shift       <= qreq_pkg::RST_SCALE_SHIFT;
         cfg_ff.source_zero_point <= qreq_pkg::RST_ZERO_POINT;
         cfg_ff.dest_zero_point   <= qreq_pkg::RST_ZERO_POINT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read data, zero extended to the bus width.
   always_comb begin
      case (reg_idx)
         qreq_pkg::REG_SOURCE_FORMAT:
            csr_prdata = qreq_pkg::DATA_W'(cfg_ff.source_format);
         qreq_pkg::REG_DEST_FORMAT:
            csr_prdata = qreq_pkg::DATA_W'(cfg_ff.dest_format);
         qreq_pkg::REG_SCALE_MULTIPLIER:
            csr_prdata = qreq_pkg::DATA_W'(cfg_ff.scale_multiplier);
         qreq_pkg::REG_SCALE_SHIFT:
            csr_prdata = qreq_pkg::DATA_W'(cfg_ff.scale_shift);
         qreq_pkg::REG_SOURCE_ZERO_POINT:
            csr_prdata = qreq_pkg::DATA_W'(cfg_ff.source_zero_point);
         qreq_pkg::REG_DEST_ZERO_POINT:
            csr_prdata = qreq_pkg::DATA_W'(cfg_ff.dest_zero_point);
         default:
            csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

>>> hw/rtl/qreq_datapath.sv
// Four-stage requantization pipeline: decode, multiply, round, saturate.
module qreq_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  qreq_pkg::cfg_type                    cfg,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [qreq_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [qreq_pkg::SAMPLE_W-1:0] rsp_converted,
   output logic                                 rsp_clipped
);

   // Stage valid bits and load enables.
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic en1, en2, en3, en4;

   // Stage payloads.
   logic [qreq_pkg::MAG_W-1:0]           mag_ff,  mag_in;
   logic                                 neg1_ff, neg1_in;
   logic [qreq_pkg::PROD_W-1:0]          prod_ff, prod_in;
   logic                                 neg2_ff;
   logic [qreq_pkg::PROD_W-1:0]          rnd_ff,  rnd_in;
   logic                                 neg3_ff;
   logic signed [qreq_pkg::SAMPLE_W-1:0] conv_ff, conv_in;
   logic                                 clip_ff, clip_in;

   // Decode stage signals.
   logic signed [qreq_pkg::MAG_W:0]      src_val;
   logic [qreq_pkg::MAG_W:0]             src_neg_val;
   logic [7:0]                           sample_byte;

   // Round stage signals.
   logic [qreq_pkg::WIDE_W-1:0]          bias;
   logic [qreq_pkg::WIDE_W-1:0]          biased;
   logic [qreq_pkg::WIDE_W-1:0]          shifted;

   // Saturate stage signals.
   logic signed [qreq_pkg::WIDE_W-1:0]   mag_s;
   logic signed [qreq_pkg::WIDE_W-1:0]   signed_val;
   logic signed [qreq_pkg::WIDE_W-1:0]   offset_val;
   logic signed [qreq_pkg::WIDE_W-1:0]   lo_bound;
   logic signed [qreq_pkg::WIDE_W-1:0]   hi_bound;

   // A stage loads when it is empty or its item moves on in the same cycle.
   assign en4       = !v4_ff || !rsp_stall;
   assign en3       = !v3_ff || en4;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_stall = !en1;

   // Decode: sign or zero extend the sample, remove the source zero point for
   // unsigned 8-bit sources, and split into sign and magnitude.
   assign sample_byte = req_sample[7:0];
   always_comb begin
      case (cfg.source_format)
         qreq_pkg::SRC_S8:
            src_val = (qreq_pkg::MAG_W+1)'($signed(sample_byte));
         qreq_pkg::SRC_U8:
            src_val = $signed({{(qreq_pkg::MAG_W+1-8){1'b0}}, sample_byte})
                    - $signed({{(qreq_pkg::MAG_W+1-qreq_pkg::ZP_W){1'b0}},
                               cfg.source_zero_point});
         default:
            src_val = (qreq_pkg::MAG_W+1)'(req_sample);
      endcase
      src_neg_val = -src_val;
      neg1_in     = src_val[qreq_pkg::MAG_W];
      mag_in      = neg1_in ? src_neg_val[qreq_pkg::MAG_W-1:0]
                            : src_val[qreq_pkg::MAG_W-1:0];
   end

   // Multiply the magnitude by the scale numerator.
   assign prod_in = qreq_pkg::PROD_W'(mag_ff) * qreq_pkg::PROD_W'(cfg.scale_multiplier);

   // Round half away from zero on the magnitude, then shift right.
   always_comb begin
      if (cfg.scale_shift == '0) begin
         bias = '0;
      end else begin
         bias = qreq_pkg::WIDE_W'(1) << (cfg.scale_shift - qreq_pkg::SHIFT_W'(1));
      end
      biased  = qreq_pkg::WIDE_W'(prod_ff) + bias;
      shifted = biased >> cfg.scale_shift;
      rnd_in  = shifted[qreq_pkg::PROD_W-1:0];
   end

   // Restore the sign, add the U8 destination zero point, and saturate.
   always_comb begin
      mag_s      = $signed(qreq_pkg::WIDE_W'(rnd_ff));
      signed_val = neg3_ff ? -mag_s : mag_s;
      case (cfg.dest_format)
         qreq_pkg::DST_S8: begin
            offset_val = signed_val;
            lo_bound   = qreq_pkg::S8_MIN;
            hi_bound   = qreq_pkg::S8_MAX;
         end
         qreq_pkg::DST_U8: begin
            offset_val = signed_val
                       + $signed(qreq_pkg::WIDE_W'(cfg.dest_zero_point));
            lo_bound   = qreq_pkg::U8_MIN;
            hi_bound   = qreq_pkg::U8_MAX;
         end
         default: begin
            offset_val = signed_val;
            lo_bound   = qreq_pkg::S32_MIN;
            hi_bound   = qreq_pkg::S32_MAX;
         end
      endcase
      if (offset_val < lo_bound) begin
         conv_in = lo_bound[qreq_pkg::SAMPLE_W-1:0];
         clip_in = 1'b1;
      end else if (offset_val > hi_bound) begin
         conv_in = hi_bound[qreq_pkg::SAMPLE_W-1:0];
         clip_in = 1'b1;
      end else begin
         conv_in = offset_val[qreq_pkg::SAMPLE_W-1:0];
         clip_in = 1'b0;
      end
   end

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   // Stage payload registers.
   always_ff @(posedge clock) begin
      if (en1) begin
         mag_ff  <= mag_in;
         neg1_ff <= neg1_in;
      end
      if (en2) begin
         prod_ff <= prod_in;
         neg2_ff <= neg1_ff;
      end
      if (en3) begin
         rnd_ff  <= rnd_in;
         neg3_ff <= neg2_ff;
      end
      if (en4) begin
         conv_ff <= conv_in;
         clip_ff <= clip_in;
      end
   end

   assign rsp_valid     = v4_ff;
   assign rsp_converted = conv_ff;
   assign rsp_clipped   = clip_ff;

endmodule
